/* src/ppmp_pkg.sv */
`default_nettype none
package ppmp_pkg;

  localparam int MAX_DIM_DEF = 4096;
  localparam int NUM_W       = 16;
  localparam int DIM_OUT_W   = 13;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = 2;

  typedef logic [NUM_W-1:0]     num_t;
  typedef logic [DIM_OUT_W-1:0] dim_out_t;

  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_P    = 8'h50;
  localparam logic [7:0] CH_3    = 8'h33;
  localparam logic [7:0] CH_6    = 8'h36;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam num_t MAXVAL_REQ    = 16'd255;

  typedef enum logic [1:0] {
    KIND_HDR = 2'd0,
    KIND_PIX = 2'd1,
    KIND_ERR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_TYPE  = 3'd0,
    ERR_ZERO  = 3'd1,
    ERR_MAXV  = 3'd2,
    ERR_STRAY = 3'd3,
    ERR_TRUNC = 3'd4,
    ERR_LARGE = 3'd5
  } err_t;

  typedef enum logic [2:0] {
    PH_MAGIC_P,
    PH_MAGIC_D,
    PH_WIDTH,
    PH_HEIGHT,
    PH_MAXVAL,
    PH_ASCII,
    PH_BINARY,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eod;
    logic       ws;
    logic       digit;
    logic       hash;
    logic       is_p;
    logic       is_3;
    logic       is_6;
    logic       is_lf;
    logic [3:0] dval;
  } byte_cls_t;

endpackage
`default_nettype wire

/* src/ppmp_front.sv */
`default_nettype none
module ppmp_front (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  output logic                       in_stall,
  input  wire  [7:0]                 in_data_byte,
  input  wire                        in_end_of_data,
  input  wire                        q_full,
  output logic                       q_push,
  output ppmp_pkg::byte_cls_t        q_item
);

  logic                 item_v_r;
  logic                 item_v_nxt;
  ppmp_pkg::byte_cls_t  item_r;
  ppmp_pkg::byte_cls_t  cls;
  logic                 accept;

  always_comb begin
    cls.data  = in_data_byte;
    cls.eod   = in_end_of_data;
    cls.ws    = (in_data_byte == ppmp_pkg::CH_SP) || (in_data_byte == ppmp_pkg::CH_TAB) ||
                (in_data_byte == ppmp_pkg::CH_CR) || (in_data_byte == ppmp_pkg::CH_LF);
    cls.digit = (in_data_byte >= ppmp_pkg::CH_0) && (in_data_byte <= ppmp_pkg::CH_9);
    cls.hash  = (in_data_byte == ppmp_pkg::CH_HASH);
    cls.is_p  = (in_data_byte == ppmp_pkg::CH_P);
    cls.is_3  = (in_data_byte == ppmp_pkg::CH_3);
    cls.is_6  = (in_data_byte == ppmp_pkg::CH_6);
    cls.is_lf = (in_data_byte == ppmp_pkg::CH_LF);
    cls.dval  = 4'(in_data_byte - ppmp_pkg::CH_0);
  end

  assign q_push   = item_v_r && !q_full;
  assign in_stall = item_v_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign q_item   = item_r;

  always_comb begin
    item_v_nxt = item_v_r;
    if (accept) begin
      item_v_nxt = 1'b1;
    end else if (q_push) begin
      item_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else begin
      item_v_r <= item_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= cls;
    end
  end

endmodule
`default_nettype wire

/* src/ppmp_queue.sv */
`default_nettype none
module ppmp_queue (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         push,
  input  wire ppmp_pkg::byte_cls_t    push_item,
  output logic                        full,
  input  wire                         pop,
  output ppmp_pkg::byte_cls_t         pop_item,
  output logic                        empty
);

  ppmp_pkg::byte_cls_t              mem [ppmp_pkg::QDEPTH];
  logic [ppmp_pkg::QPTR_W-1:0]      wr_ptr_r;
  logic [ppmp_pkg::QPTR_W-1:0]      wr_ptr_nxt;
  logic [ppmp_pkg::QPTR_W-1:0]      rd_ptr_r;
  logic [ppmp_pkg::QPTR_W-1:0]      rd_ptr_nxt;
  logic [ppmp_pkg::QPTR_W:0]        count_r;
  logic [ppmp_pkg::QPTR_W:0]        count_nxt;
  logic                             do_push;
  logic                             do_pop;

  assign full     = (count_r == (ppmp_pkg::QPTR_W+1)'(ppmp_pkg::QDEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

/* src/ppmp_back.sv */
`default_nettype none
module ppmp_back #(
  parameter int MAX_DIM = ppmp_pkg::MAX_DIM_DEF
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           q_empty,
  input  wire ppmp_pkg::byte_cls_t      q_item,
  output logic                          q_pop,
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic [1:0]                    out_kind,
  output logic [2:0]                    out_error_code,
  output logic [ppmp_pkg::DIM_OUT_W-1:0] out_image_width,
  output logic [ppmp_pkg::DIM_OUT_W-1:0] out_image_height,
  output logic [7:0]                    out_red,
  output logic [7:0]                    out_green,
  output logic [7:0]                    out_blue,
  output logic                          out_last_pixel
);

  localparam int DW    = $clog2(MAX_DIM + 1);
  localparam int CNT_W = 2 * DW;
  localparam int NW    = ppmp_pkg::NUM_W;
  localparam ppmp_pkg::num_t DIM_LIM = ppmp_pkg::num_t'(MAX_DIM);

  ppmp_pkg::phase_t  phase_r, phase_nxt;
  logic              in_comment_r, in_comment_nxt;
  ppmp_pkg::num_t    acc_r, acc_nxt;
  logic              digit_seen_r, digit_seen_nxt;
  ppmp_pkg::num_t    w_r, w_nxt;
  ppmp_pkg::num_t    h_r, h_nxt;
  logic              binary_r, binary_nxt;
  logic [1:0]        ch_r, ch_nxt;
  logic [7:0]        red_r, red_nxt;
  logic [7:0]        green_r, green_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              err_r, err_nxt;

  logic              out_valid_r;
  ppmp_pkg::kind_t   kind_r, kind_nxt;
  ppmp_pkg::err_t    code_r, code_nxt;
  ppmp_pkg::dim_out_t ow_r, ow_nxt;
  ppmp_pkg::dim_out_t oh_r, oh_nxt;
  logic [7:0]        or_r, or_nxt;
  logic [7:0]        og_r, og_nxt;
  logic [7:0]        ob_r, ob_nxt;
  logic              olast_r, olast_nxt;

  logic              step, go, eod;
  logic              num_ph, open_txt;
  logic [NW+3:0]     acc_ext, acc_mul;
  ppmp_pkg::num_t    acc_digit, end_v;
  logic              hash_err, stray, digit_upd, end_num;
  logic              comment_set, comment_clr;
  logic              magic_d_ok;
  logic              hdr_end, hdr_zero, hdr_big, hdr_badmax, hdr_ok;
  logic              take, pixel_fire, last_hit;
  logic [7:0]        take_v;
  logic              err_fire;
  ppmp_pkg::err_t    err_code;
  logic              trunc, res_valid;
  logic [CNT_W-1:0]  product;

  assign step     = !q_empty && (!out_valid_r || !out_stall);
  assign q_pop    = step;
  assign eod      = q_item.eod;
  assign go       = step && !err_r && (phase_r != ppmp_pkg::PH_DONE);
  assign num_ph   = (phase_r == ppmp_pkg::PH_WIDTH) || (phase_r == ppmp_pkg::PH_HEIGHT) ||
                    (phase_r == ppmp_pkg::PH_MAXVAL) || (phase_r == ppmp_pkg::PH_ASCII);
  assign open_txt = num_ph && !in_comment_r;

  assign acc_ext  = {4'b0, acc_r};
  assign acc_mul  = (acc_ext << 3) + (acc_ext << 1) + {{NW{1'b0}}, q_item.dval};
  always_comb begin
    if (phase_r == ppmp_pkg::PH_ASCII) begin
      acc_digit = acc_mul[NW-1:0];
    end else if (|acc_mul[NW+3:NW]) begin
      acc_digit = '1;
    end else begin
      acc_digit = acc_mul[NW-1:0];
    end
  end
  assign end_v = (q_item.digit && (phase_r == ppmp_pkg::PH_ASCII)) ? acc_digit : acc_r;

  assign hash_err    = q_item.hash && (phase_r == ppmp_pkg::PH_MAXVAL) && binary_r &&
                       digit_seen_r;
  assign stray       = !q_item.digit && !q_item.ws && !q_item.hash;
  assign digit_upd   = go && open_txt && q_item.digit;
  assign end_num     = go && open_txt &&
                       ((q_item.digit && (phase_r == ppmp_pkg::PH_ASCII) && eod) ||
                        ((q_item.ws || (q_item.hash && !hash_err)) && digit_seen_r));
  assign comment_set = go && !in_comment_r && q_item.hash &&
                       ((phase_r == ppmp_pkg::PH_MAGIC_P) || (num_ph && !hash_err));
  assign comment_clr = go && in_comment_r && q_item.is_lf &&
                       (phase_r != ppmp_pkg::PH_BINARY) && (phase_r != ppmp_pkg::PH_MAGIC_D);
  assign magic_d_ok  = q_item.is_3 || q_item.is_6;

  assign hdr_end    = end_num && (phase_r == ppmp_pkg::PH_MAXVAL);
  assign hdr_zero   = (w_r == '0) || (h_r == '0);
  assign hdr_big    = (w_r > DIM_LIM) || (h_r > DIM_LIM);
  assign hdr_badmax = (end_v != ppmp_pkg::MAXVAL_REQ);
  assign hdr_ok     = hdr_end && !hdr_zero && !hdr_big && !hdr_badmax;
  assign product    = CNT_W'(w_r[DW-1:0]) * CNT_W'(h_r[DW-1:0]);

  assign take       = (go && (phase_r == ppmp_pkg::PH_BINARY)) ||
                      (end_num && (phase_r == ppmp_pkg::PH_ASCII));
  assign take_v     = (phase_r == ppmp_pkg::PH_BINARY) ? q_item.data : end_v[7:0];
  assign pixel_fire = take && ch_r[1];
  assign last_hit   = (count_r == CNT_W'(1));

  always_comb begin
    err_fire = 1'b0;
    err_code = ppmp_pkg::ERR_TYPE;
    if (go) begin
      if (phase_r == ppmp_pkg::PH_MAGIC_D) begin
        err_fire = !magic_d_ok;
      end else if ((phase_r == ppmp_pkg::PH_MAGIC_P) && !in_comment_r) begin
        err_fire = !q_item.ws && !q_item.hash && !q_item.is_p;
      end else if (open_txt) begin
        if (hash_err || stray) begin
          err_fire = 1'b1;
          err_code = ppmp_pkg::ERR_STRAY;
        end else if (hdr_end && hdr_zero) begin
          err_fire = 1'b1;
          err_code = ppmp_pkg::ERR_ZERO;
        end else if (hdr_end && hdr_big) begin
          err_fire = 1'b1;
          err_code = ppmp_pkg::ERR_LARGE;
        end else if (hdr_end && hdr_badmax) begin
          err_fire = 1'b1;
          err_code = ppmp_pkg::ERR_MAXV;
        end
      end
    end
  end

  assign trunc     = go && eod && !err_fire && !(pixel_fire && last_hit);
  assign res_valid = trunc || err_fire || hdr_ok || pixel_fire;

  always_comb begin
    phase_nxt = phase_r;
    if (step && eod) begin
      phase_nxt = ppmp_pkg::PH_MAGIC_P;
    end else if (go) begin
      unique case (phase_r)
        ppmp_pkg::PH_MAGIC_P: begin
          if (!in_comment_r && q_item.is_p) phase_nxt = ppmp_pkg::PH_MAGIC_D;
        end
        ppmp_pkg::PH_MAGIC_D: begin
          if (magic_d_ok) phase_nxt = ppmp_pkg::PH_WIDTH;
        end
        ppmp_pkg::PH_WIDTH: begin
          if (end_num) phase_nxt = ppmp_pkg::PH_HEIGHT;
        end
        ppmp_pkg::PH_HEIGHT: begin
          if (end_num) phase_nxt = ppmp_pkg::PH_MAXVAL;
        end
        ppmp_pkg::PH_MAXVAL: begin
          if (hdr_ok) phase_nxt = binary_r ? ppmp_pkg::PH_BINARY : ppmp_pkg::PH_ASCII;
        end
        ppmp_pkg::PH_ASCII, ppmp_pkg::PH_BINARY: begin
          if (pixel_fire && last_hit) phase_nxt = ppmp_pkg::PH_DONE;
        end
        ppmp_pkg::PH_DONE: begin
          phase_nxt = phase_r;
        end
        default: begin
          phase_nxt = ppmp_pkg::PH_MAGIC_P;
        end
      endcase
    end
  end

  always_comb begin
    kind_nxt  = ppmp_pkg::KIND_HDR;
    code_nxt  = ppmp_pkg::ERR_TYPE;
    ow_nxt    = '0;
    oh_nxt    = '0;
    or_nxt    = '0;
    og_nxt    = '0;
    ob_nxt    = '0;
    olast_nxt = 1'b0;
    if (trunc) begin
      kind_nxt = ppmp_pkg::KIND_ERR;
      code_nxt = ppmp_pkg::ERR_TRUNC;
    end else if (err_fire) begin
      kind_nxt = ppmp_pkg::KIND_ERR;
      code_nxt = err_code;
    end else if (hdr_ok) begin
      kind_nxt = ppmp_pkg::KIND_HDR;
      ow_nxt   = w_r[ppmp_pkg::DIM_OUT_W-1:0];
      oh_nxt   = h_r[ppmp_pkg::DIM_OUT_W-1:0];
    end else if (pixel_fire) begin
      kind_nxt  = ppmp_pkg::KIND_PIX;
      or_nxt    = red_r;
      og_nxt    = green_r;
      ob_nxt    = take_v;
      olast_nxt = last_hit;
    end
  end

  always_comb begin
    in_comment_nxt = in_comment_r;
    acc_nxt        = acc_r;
    digit_seen_nxt = digit_seen_r;
    w_nxt          = w_r;
    h_nxt          = h_r;
    binary_nxt     = binary_r;
    ch_nxt         = ch_r;
    red_nxt        = red_r;
    green_nxt      = green_r;
    count_nxt      = count_r;
    err_nxt        = err_r;
    if (step && eod) begin
      in_comment_nxt = 1'b0;
      acc_nxt        = '0;
      digit_seen_nxt = 1'b0;
      ch_nxt         = '0;
      err_nxt        = 1'b0;
    end else if (go) begin
      err_nxt = err_fire;
      if (comment_set) in_comment_nxt = 1'b1;
      if (comment_clr) in_comment_nxt = 1'b0;
      if (digit_upd) begin
        acc_nxt        = acc_digit;
        digit_seen_nxt = 1'b1;
      end
      if (end_num) begin
        acc_nxt        = '0;
        digit_seen_nxt = 1'b0;
        if (phase_r == ppmp_pkg::PH_WIDTH) w_nxt = end_v;
        if (phase_r == ppmp_pkg::PH_HEIGHT) h_nxt = end_v;
      end
      if ((phase_r == ppmp_pkg::PH_MAGIC_D) && magic_d_ok) binary_nxt = q_item.is_6;
      if (take) begin
        case (ch_r)
          2'd0: begin
            red_nxt = take_v;
            ch_nxt  = 2'd1;
          end
          2'd1: begin
            green_nxt = take_v;
            ch_nxt    = 2'd2;
          end
          default: begin
            ch_nxt = 2'd0;
          end
        endcase
      end
      if (hdr_ok) begin
        count_nxt = product;
        ch_nxt    = '0;
      end
      if (pixel_fire && !last_hit) count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= ppmp_pkg::PH_MAGIC_P;
      in_comment_r <= 1'b0;
      acc_r        <= '0;
      digit_seen_r <= 1'b0;
      ch_r         <= '0;
      err_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      in_comment_r <= in_comment_nxt;
      acc_r        <= acc_nxt;
      digit_seen_r <= digit_seen_nxt;
      ch_r         <= ch_nxt;
      err_r        <= err_nxt;
      if (step && res_valid) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    w_r      <= w_nxt;
    h_r      <= h_nxt;
    binary_r <= binary_nxt;
    red_r    <= red_nxt;
    green_r  <= green_nxt;
    count_r  <= count_nxt;
    if (step && res_valid) begin
      kind_r  <= kind_nxt;
      code_r  <= code_nxt;
      ow_r    <= ow_nxt;
      oh_r    <= oh_nxt;
      or_r    <= or_nxt;
      og_r    <= og_nxt;
      ob_r    <= ob_nxt;
      olast_r <= olast_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = kind_r;
  assign out_error_code   = code_r;
  assign out_image_width  = ow_r;
  assign out_image_height = oh_r;
  assign out_red          = or_r;
  assign out_green        = og_r;
  assign out_blue         = ob_r;
  assign out_last_pixel   = olast_r;

endmodule
`default_nettype wire

/* src/ppm_image_stream_parser_unit.sv */
`default_nettype none
// Channel   Ports                                         Direction
// input     in_valid, in_stall, in_data_byte, in_end_of_data    in (in_stall out)
// result    out_valid, out_stall, out_kind .. out_last_pixel    out (out_stall in)
//
// One byte is accepted per cycle while in_stall is low, and each byte gives
// zero or one result. A result is presented once its byte has passed the
// front register and the queue into the output register. The four-entry
// queue absorbs result stalls; in_stall rises when it is full and a byte waits.
// Reset is synchronous on rst_n and returns the parser to the start of a file.
module ppm_image_stream_parser_unit #(
  parameter int MAX_DIM = ppmp_pkg::MAX_DIM_DEF
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire  [7:0]                     in_data_byte,
  input  wire                            in_end_of_data,
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic [1:0]                     out_kind,
  output logic [2:0]                     out_error_code,
  output logic [ppmp_pkg::DIM_OUT_W-1:0] out_image_width,
  output logic [ppmp_pkg::DIM_OUT_W-1:0] out_image_height,
  output logic [7:0]                     out_red,
  output logic [7:0]                     out_green,
  output logic [7:0]                     out_blue,
  output logic                           out_last_pixel
);

  logic                 q_full;
  logic                 q_empty;
  logic                 q_push;
  logic                 q_pop;
  ppmp_pkg::byte_cls_t  q_in_item;
  ppmp_pkg::byte_cls_t  q_out_item;

  ppmp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_end_of_data (in_end_of_data),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_item         (q_in_item)
  );

  ppmp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_out_item),
    .empty     (q_empty)
  );

  ppmp_back #(
    .MAX_DIM (MAX_DIM)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_item           (q_out_item),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_error_code   (out_error_code),
    .out_image_width  (out_image_width),
    .out_image_height (out_image_height),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_last_pixel   (out_last_pixel)
  );

  a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_full && q_empty))
    else $error("queue reports full and empty together");

  a_pop_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (!q_empty && (!out_valid || !out_stall)))
    else $error("queue popped while the result register was blocked");

  a_pixel_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == ppmp_pkg::KIND_PIX)) |->
      ((out_error_code == 3'd0) && (out_image_width == '0) && (out_image_height == '0)))
    else $error("pixel request carries header or error fields");

  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == ppmp_pkg::KIND_ERR)) |->
      ((out_red == '0) && (out_green == '0) && (out_blue == '0) && !out_last_pixel))
    else $error("error request carries pixel fields");

endmodule
`default_nettype wire
